// ===== rtl/core/double_round_to_integral_defines.svh =====
// Assertion macros for the checker file.
`ifndef DOUBLE_ROUND_TO_INTEGRAL_DEFINES_SVH
`define DOUBLE_ROUND_TO_INTEGRAL_DEFINES_SVH

// An implication checked on every rising clock edge outside reset.
`define DRI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A next-cycle implication checked outside reset.
`define DRI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dri_pkg.sv =====
package dri_pkg;

    localparam int unsigned WordWidth = 64;
    localparam int unsigned ExpWidth  = 11;
    localparam int unsigned FracWidth = 52;

    localparam logic [ExpWidth-1:0] ExpBias     = 11'd1023;
    localparam logic [ExpWidth-1:0] ExpIntegral = 11'd1075;
    localparam logic [WordWidth-1:0] OneBits    = 64'h3FF0_0000_0000_0000;

    typedef enum logic [1:0] {
        MODE_NEAREST = 2'd0,
        MODE_CEIL    = 2'd1,
        MODE_FLOOR   = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_t;

    // Decoded operand passed from the analysis stage to the decision stage.
    typedef struct packed {
        logic [WordWidth-1:0] bits;
        logic                 pass;       // returned unchanged
        logic                 sub_one;    // magnitude below one
        logic                 half_exp;   // exponent of one half
        logic                 frac_nz;    // fraction bits below integer point set
        logic                 above_half; // fraction greater than one half
        logic                 is_half;    // fraction exactly one half
        logic                 lsb;        // integer least significant bit
        logic [WordWidth-1:0] unit;       // weight of the integer LSB
        logic [WordWidth-1:0] trunc;      // truncated magnitude bits
    } dec_t;

    // Decision passed to the final adder stage.
    typedef struct packed {
        logic [WordWidth-1:0] bits;
        logic                 pass;
        logic                 sub_one;
        logic                 inc;
        logic [WordWidth-1:0] unit;
        logic [WordWidth-1:0] trunc;
    } act_t;

endpackage

// ===== rtl/core/dri_decode.sv =====
module dri_decode
    import dri_pkg::*;
(
    input  logic [WordWidth-1:0] bits,
    output dec_t                 dec
);

    logic [ExpWidth-1:0]  ex;
    logic [WordWidth-1:0] mag;
    logic [5:0]           f;
    logic [WordWidth-1:0] mask;
    logic [WordWidth-1:0] half;
    logic [WordWidth-1:0] frac;
    logic [ExpWidth-1:0]  fdiff;

    // Fraction position and masks from the exponent.
    always_comb
    begin
        ex    = bits[WordWidth-2 -: ExpWidth];
        mag   = {1'b0, bits[WordWidth-2:0]};
        fdiff = ExpIntegral - ex;
        f     = fdiff[5:0];
        mask  = (64'd1 << f) - 64'd1;
        half  = 64'd1 << (f - 6'd1);
        frac  = mag & mask;
        dec.bits       = bits;
        dec.pass       = (ex >= ExpIntegral) || (mag == '0);
        dec.sub_one    = ex < ExpBias;
        dec.half_exp   = ex == (ExpBias - 11'd1);
        dec.frac_nz    = (ex < ExpBias) ? (mag[FracWidth-1:0] != '0) : (frac != '0);
        dec.above_half = frac > half;
        dec.is_half    = frac == half;
        dec.lsb        = |(mag & (mask + 64'd1));
        dec.unit       = mask + 64'd1;
        dec.trunc      = mag & ~mask;
    end

endmodule

// ===== rtl/core/dri_decide.sv =====
module dri_decide
    import dri_pkg::*;
(
    input  dec_t        dec,
    input  logic [1:0]  mode,
    output act_t        act
);

    logic neg;

    // Whether the magnitude moves up by one unit.
    always_comb
    begin
        neg         = dec.bits[WordWidth-1];
        act.bits    = dec.bits;
        act.sub_one = dec.sub_one;
        act.unit    = dec.unit;
        act.trunc   = dec.trunc;
        act.pass    = dec.pass || (!dec.sub_one && !dec.frac_nz);
        case (mode_t'(mode))
            MODE_CEIL:  act.inc = !neg;
            MODE_FLOOR: act.inc = neg;
            default:
            begin
                if (dec.sub_one)
                    act.inc = dec.half_exp && dec.frac_nz;
                else
                    act.inc = dec.above_half || (dec.is_half && dec.lsb);
            end
        endcase
    end

endmodule

// ===== rtl/core/double_round_to_integral.sv =====
// Channel   Direction  Handshake         Payload
// operand   in         valid / stall     operand_bits (64)
// result    out        valid / stall     rounded_bits (64)
// config    in         valid / ready     rounding_mode (2)
//
// An item is decoded, judged and rounded in three register stages.
// An item moves through the decode, act and result registers; the last presents it as valid.
// One item can enter every cycle unless the input is stalled; a stage loads when its downstream slot frees.
// A stall on the result holds the result stage and each occupied stage behind a held one; empty stages still fill.
// Reset clears the valid bits and sets the mode to nearest, ties to even.
module double_round_to_integral
    import dri_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WordWidth-1:0] operand_bits,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WordWidth-1:0] rounded_bits,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           rounding_mode
);

    logic [1:0]           mode_reg;
    logic                 v0_reg, v1_reg, v2_reg;
    logic                 en0, en1, en2;
    dec_t                 dec_comb, dec_reg;
    act_t                 act_comb, act_reg;
    logic [WordWidth-1:0] res_next, res_reg;
    logic [WordWidth-1:0] sum;

    assign cfg_ready = 1'b1;

    // Stage enables: a stage loads when its downstream slot frees.
    assign en2      = !v2_reg || !out_stall;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign in_stall = !en0;

    dri_decode u_decode (.bits(operand_bits), .dec(dec_comb));
    dri_decide u_decide (.dec(dec_reg), .mode(mode_reg), .act(act_comb));

    // Final result from the decision.
    always_comb
    begin
        sum = act_reg.trunc + act_reg.unit;
        if (act_reg.pass)
            res_next = act_reg.bits;
        else if (act_reg.sub_one)
            res_next = {act_reg.bits[WordWidth-1], 63'd0} | (act_reg.inc ? OneBits : '0);
        else
            res_next = {act_reg.bits[WordWidth-1],
                        (act_reg.inc ? sum[WordWidth-2:0] : act_reg.trunc[WordWidth-2:0])};
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NEAREST;
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                mode_reg <= rounding_mode;
            if (en0)
                v0_reg <= in_valid;
            if (en1)
                v1_reg <= v0_reg;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en0)
            dec_reg <= dec_comb;
        if (en1)
            act_reg <= act_comb;
        if (en2)
            res_reg <= res_next;
    end

    // The final register holds the rounded word; the act stage feeds it.
    assign out_valid    = v2_reg;
    assign rounded_bits = res_reg;

endmodule

// ===== rtl/core/dri_checker.sv =====
`include "double_round_to_integral_defines.svh"

module dri_checker
    import dri_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [WordWidth-1:0] rounded_bits
);

    // A stalled result holds.
    `DRI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(rounded_bits), "result changed under stall")
    // Input stalls only when the output is stalled.
    `DRI_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_stall && out_valid, "input stalled without output stall")
    // An accepted item is presented as a result when the output runs freely after its acceptance.
    `DRI_ASSERT_NEXT(a_latency, clk, rst_n, in_valid && !in_stall ##1 !out_stall [*2], out_valid, "result missing after an accepted item")

endmodule

bind double_round_to_integral dri_checker u_dri_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .rounded_bits(rounded_bits)
);

// ===== verif/double_round_to_integral_tb.sv =====
`timescale 1ns / 100ps

module double_round_to_integral_tb;
    import dri_pkg::*;

    localparam int unsigned IdleLimit = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [WordWidth-1:0] operand_bits;
    logic                 out_valid;
    logic                 out_stall;
    logic [WordWidth-1:0] rounded_bits;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           rounding_mode;

    // Mode as the predictor sees it, and the queue of predicted roundings.
    logic [1:0]           mode_shadow;
    logic [WordWidth-1:0] rounded_queue[$];
    int unsigned          error_count;
    int unsigned          idle_cycles;
    bit                   quiet_tail;
    bit                   stimulus_done;

    double_round_to_integral dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operand_bits (operand_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rounded_bits (rounded_bits),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .rounding_mode(rounding_mode)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Expected integral value of one operand under the given mode.
    function automatic logic [WordWidth-1:0] round_integral(
        input logic [WordWidth-1:0] x, input logic [1:0] mode);
        logic                 neg;
        logic [WordWidth-1:0] mag;
        logic [ExpWidth-1:0]  ex;
        int unsigned          fbits;
        logic [WordWidth-1:0] mask;
        logic [WordWidth-1:0] frac;
        logic [WordWidth-1:0] trunc;
        logic [WordWidth-1:0] half;
        logic                 inc;
        neg = x[WordWidth-1];
        mag = {1'b0, x[WordWidth-2:0]};
        ex = x[WordWidth-2 -: ExpWidth];
        if (ex >= ExpIntegral || mag == '0)
            return x;
        if (ex < ExpBias)
        begin
            if (mode == MODE_CEIL)
                inc = !neg;
            else if (mode == MODE_FLOOR)
                inc = neg;
            else
                inc = (ex == ExpBias - 11'd1) && (x[FracWidth-1:0] != '0);
            return {neg, 63'd0} | (inc ? OneBits : '0);
        end
        fbits = ExpIntegral - ex;
        mask = (64'd1 << fbits) - 64'd1;
        frac = mag & mask;
        if (frac == '0)
            return x;
        trunc = mag & ~mask;
        if (mode == MODE_CEIL)
            inc = !neg;
        else if (mode == MODE_FLOOR)
            inc = neg;
        else
        begin
            half = 64'd1 << (fbits - 1);
            inc = (frac > half) || (frac == half && mag[fbits]);
        end
        if (inc)
            trunc = trunc + (64'd1 << fbits);
        return {neg, 63'd0} | trunc;
    endfunction

    // Occasional idle burst of random length, skipped in the quiet tail.
    task automatic idle_burst();
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    // Send one operand and record its predicted rounding on acceptance.
    // The valid stays high afterwards so that items can follow back to back.
    task automatic send_operand(input logic [WordWidth-1:0] value);
        idle_burst();
        in_valid <= 1'b1;
        operand_bits <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rounded_queue.push_back(round_integral(value, mode_shadow));
        @(negedge clk);
    endtask

    // Wait until every predicted item has come back, then let the pipeline drain.
    task automatic drain();
        in_valid <= 1'b0;
        while (rounded_queue.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Write the rounding mode while the block is idle.
    task automatic write_mode(input logic [1:0] mode);
        drain();
        cfg_valid <= 1'b1;
        rounding_mode <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_shadow = mode;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Build a double from sign, biased exponent and fraction.
    function automatic logic [WordWidth-1:0] make_double(
        input logic s, input logic [ExpWidth-1:0] e, input logic [FracWidth-1:0] f);
        return {s, e, f};
    endfunction

    // Operand biased towards the exponents where rounding happens.
    function automatic logic [WordWidth-1:0] random_operand();
        logic [ExpWidth-1:0] e;
        case ($urandom_range(0, 9))
            0: e = 11'($urandom_range(0, 2047));
            1: e = 11'($urandom_range(0, 3));
            2: e = 11'($urandom_range(1070, 1080));
            3: e = 11'h7FF;
            default: e = 11'($urandom_range(1019, 1075));
        endcase
        return make_double(1'($urandom_range(0, 1)), e,
            52'({$urandom(), $urandom()} >> ($urandom_range(0, 1) ? 0 : $urandom_range(0, 52))));
    endfunction

    // Directed edge cases under one mode.
    task automatic test_edges();
        send_operand(64'd0);
        send_operand(64'h8000_0000_0000_0000);
        send_operand(64'h0000_0000_0000_0001);
        send_operand(64'h8000_0000_0000_0001);
        send_operand(64'h3FE0_0000_0000_0000);   // one half
        send_operand(64'hBFE0_0000_0000_0000);
        send_operand(64'h3FE0_0000_0000_0001);
        send_operand(64'h3FF8_0000_0000_0000);   // 1.5
        send_operand(64'hBFF8_0000_0000_0000);
        send_operand(64'h4004_0000_0000_0000);   // 2.5
        send_operand(64'hC004_0000_0000_0000);
        send_operand(64'h432F_FFFF_FFFF_FFFF);   // just below 2^52 with a half
        send_operand(64'h4330_0000_0000_0001);   // 2^52 and above pass through
        send_operand(64'h7FF0_0000_0000_0000);
        send_operand(64'hFFF0_0000_0000_0000);
        send_operand(64'h7FF0_0000_0000_0001);   // signalling NaN kept as is
        send_operand(64'hFFFF_FFFF_FFFF_FFFF);
        send_operand(64'h3FEF_FFFF_FFFF_FFFF);   // carry into the exponent
        send_operand(64'hC32F_FFFF_FFFF_FFFE);
    endtask

    // Random operands under the current mode.
    task automatic test_random(input int unsigned count);
        repeat (count)
            send_operand(random_operand());
    endtask

    // Sender holds back until every result is back, then resumes.
    task automatic test_full_drain();
        test_random(30);
        in_valid <= 1'b0;
        while (rounded_queue.size() != 0)
            @(negedge clk);
        test_random(30);
    endtask

    // Result stall: random bursts, none in the quiet tail.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (rounded_queue.size() == 0)
            begin
                $display("%0t: unexpected item, actual %h", $time, rounded_bits);
                error_count++;
            end
            else if (rounded_bits !== rounded_queue[0])
            begin
                $display("%0t: mismatch, expected %h actual %h",
                    $time, rounded_queue[0], rounded_bits);
                error_count++;
                void'(rounded_queue.pop_front());
            end
            else
                void'(rounded_queue.pop_front());
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || (stimulus_done && rounded_queue.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operand_bits = '0;
        cfg_valid = 1'b0;
        rounding_mode = MODE_NEAREST;
        mode_shadow = MODE_NEAREST;
        error_count = 0;
        idle_cycles = 0;
        quiet_tail = 1'b0;
        stimulus_done = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset mode is nearest, ties to even.
        test_edges();
        write_mode(MODE_CEIL);
        test_edges();
        write_mode(MODE_FLOOR);
        test_edges();
        write_mode(MODE_SPARE);
        test_edges();
        test_random(100);
        write_mode(MODE_NEAREST);
        test_random(400);
        test_full_drain();
        write_mode(MODE_CEIL);
        test_random(350);
        write_mode(MODE_FLOOR);
        test_random(350);
        write_mode(MODE_NEAREST);
        quiet_tail = 1'b1;
        test_random(300);

        stimulus_done = 1'b1;
        drain();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dri_pkg.sv
rtl/core/dri_decode.sv
rtl/core/dri_decide.sv
rtl/core/double_round_to_integral.sv
rtl/core/dri_checker.sv
verif/double_round_to_integral_tb.sv
